[hdl/fnvlp_pkg.sv]
// Shared constants, types and helper functions for the FNV-1a hash table core.
// Used by fnvlp_ctrl, fnvlp_dp and the top level; depends on nothing else.
`timescale 1ns / 1ps

package fnvlp_pkg;

    localparam int TABLE_SLOTS = 64;
    localparam int KEY_BYTES   = 8;
    localparam int SLOT_W      = $clog2(TABLE_SLOTS);
    localparam int KEY_W       = 64;
    localparam int VALUE_W     = 32;
    localparam int HASH_W      = 32;

    localparam logic [HASH_W-1:0] FNV_BASIS = 32'd2166136261;
    localparam logic [HASH_W-1:0] FNV_PRIME = 32'd16777619;

    localparam logic REQ_PUT = 1'b0;
    localparam logic REQ_GET = 1'b1;

    typedef enum logic [2:0] {
        ST_INSERTED  = 3'd0,
        ST_UPDATED   = 3'd1,
        ST_FOUND     = 3'd2,
        ST_NOT_FOUND = 3'd3,
        ST_FULL      = 3'd4
    } t_status;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic    load_req;
        logic    hash_step;
        logic    probe_start;
        logic    probe_next;
        logic    write_key;
        logic    write_value;
        logic    set_used;
        logic    capture;
        logic    take_value;
        t_status status;
        logic    load_out;
    } t_dp_cmd;

    // Status from the datapath back to the controller.
    typedef struct packed {
        logic is_get;
        logic hkey_zero;
        logic slot_used;
        logic key_match;
        logic probe_last;
    } t_dp_sts;

    // Keeps the bytes before the first zero byte and below KEY_BYTES.
    function automatic logic [KEY_W-1:0] key_normalize(input logic [KEY_W-1:0] raw);
        logic [KEY_W-1:0] kept;
        logic             alive;
        kept  = '0;
        alive = 1'b1;
        for (int i = 0; i < KEY_W / 8; i++) begin
            if (i >= KEY_BYTES || raw[8*i +: 8] == 8'h00) begin
                alive = 1'b0;
            end
            if (alive) begin
                kept[8*i +: 8] = raw[8*i +: 8];
            end
        end
        return kept;
    endfunction

endpackage

[hdl/fnvlp_ctrl.sv]
// Request sequencer for the hash table core: hashing, probing and result hand-off.
// Depends on fnvlp_pkg; drives fnvlp_dp through t_dp_cmd and reads t_dp_sts.
`timescale 1ns / 1ps

module fnvlp_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    output logic               o_valid,
    input  logic               i_stall,
    input  fnvlp_pkg::t_dp_sts i_sts,
    output fnvlp_pkg::t_dp_cmd o_cmd
);
    import fnvlp_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_HASH   = 5'b00010,
        S_PROBE  = 5'b00100,
        S_CHECK  = 5'b01000,
        S_RESULT = 5'b10000
    } t_state;

    t_state  r_state, n_state;
    logic    r_out_valid, n_out_valid;
    t_dp_cmd cmd;

    always_comb begin
        n_state = r_state;
        cmd     = '0;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    cmd.load_req = 1'b1;
                    n_state      = S_HASH;
                end
            end
            S_HASH: begin
                if (!i_sts.hkey_zero) begin
                    cmd.hash_step = 1'b1;
                end else begin
                    cmd.probe_start = 1'b1;
                    n_state         = S_PROBE;
                end
            end
            S_PROBE: begin
                if (!i_sts.slot_used) begin
                    cmd.capture = 1'b1;
                    if (i_sts.is_get) begin
                        cmd.status = ST_NOT_FOUND;
                    end else begin
                        cmd.status      = ST_INSERTED;
                        cmd.write_key   = 1'b1;
                        cmd.write_value = 1'b1;
                        cmd.set_used    = 1'b1;
                    end
                    n_state = S_RESULT;
                end else begin
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                if (i_sts.key_match) begin
                    cmd.capture = 1'b1;
                    if (i_sts.is_get) begin
                        cmd.status     = ST_FOUND;
                        cmd.take_value = 1'b1;
                    end else begin
                        cmd.status      = ST_UPDATED;
                        cmd.write_value = 1'b1;
                    end
                    n_state = S_RESULT;
                end else if (i_sts.probe_last) begin
                    cmd.capture = 1'b1;
                    cmd.status  = i_sts.is_get ? ST_NOT_FOUND : ST_FULL;
                    n_state     = S_RESULT;
                end else begin
                    cmd.probe_next = 1'b1;
                    n_state        = S_PROBE;
                end
            end
            S_RESULT: begin
                // The result register may still hold an untaken word.
                if (!r_out_valid || !i_stall) begin
                    cmd.load_out = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (cmd.load_out) begin
            n_out_valid = 1'b1;
        end else if (r_out_valid && !i_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_stall = (r_state != S_IDLE);
    assign o_valid = r_out_valid;
    assign o_cmd   = cmd;

    a_load_out_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.load_out |-> (!r_out_valid || !i_stall))
        else $error("result loaded over an untaken word");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> o_stall)
        else $error("second request taken while one is in flight");

    a_capture_then_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.capture |=> (r_state == S_RESULT))
        else $error("captured result not followed by hand-off");

endmodule

[hdl/fnvlp_dp.sv]
// Datapath of the hash table core: FNV-1a hash unit, slot memories, used bits,
// probe index and result registers. Depends on fnvlp_pkg; steered by fnvlp_ctrl.
`timescale 1ns / 1ps

module fnvlp_dp (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  fnvlp_pkg::t_dp_cmd                      i_cmd,
    output fnvlp_pkg::t_dp_sts                      o_sts,
    input  logic                                    i_req_type,
    input  logic        [fnvlp_pkg::KEY_W-1:0]      i_key,
    input  logic signed [fnvlp_pkg::VALUE_W-1:0]    i_value,
    output logic        [2:0]                       o_status,
    output logic signed [fnvlp_pkg::VALUE_W-1:0]    o_read_value
);
    import fnvlp_pkg::*;

    logic                      r_is_get;
    logic [KEY_W-1:0]          r_nkey;
    logic [KEY_W-1:0]          r_hkey;
    logic signed [VALUE_W-1:0] r_value;
    logic [HASH_W-1:0]         r_hash;
    logic [SLOT_W-1:0]         r_idx;
    logic [SLOT_W-1:0]         r_probe_cnt;
    logic [TABLE_SLOTS-1:0]    r_used;

    logic [KEY_W-1:0]          r_key_mem [TABLE_SLOTS];
    logic signed [VALUE_W-1:0] r_val_mem [TABLE_SLOTS];
    logic [KEY_W-1:0]          r_rd_key;
    logic signed [VALUE_W-1:0] r_rd_val;

    t_status                   r_res_status;
    logic signed [VALUE_W-1:0] r_res_value;
    t_status                   r_out_status;
    logic signed [VALUE_W-1:0] r_out_value;

    logic [HASH_W-1:0]         n_hash;

    // One FNV-1a byte step per cycle; the shifted key copy runs out at the terminator.
    assign n_hash = (r_hash ^ {{(HASH_W-8){1'b0}}, r_hkey[7:0]}) * FNV_PRIME;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_req) begin
            r_is_get <= (i_req_type == REQ_GET);
            r_nkey   <= key_normalize(i_key);
            r_hkey   <= key_normalize(i_key);
            r_value  <= i_value;
            r_hash   <= FNV_BASIS;
        end else if (i_cmd.hash_step) begin
            r_hash <= n_hash;
            r_hkey <= r_hkey >> 8;
        end

        if (i_cmd.probe_start) begin
            r_idx       <= r_hash[SLOT_W-1:0];
            r_probe_cnt <= '0;
        end else if (i_cmd.probe_next) begin
            r_idx       <= r_idx + SLOT_W'(1);
            r_probe_cnt <= r_probe_cnt + SLOT_W'(1);
        end

        if (i_cmd.capture) begin
            r_res_status <= i_cmd.status;
            r_res_value  <= i_cmd.take_value ? r_rd_val : '0;
        end
        if (i_cmd.load_out) begin
            r_out_status <= r_res_status;
            r_out_value  <= r_res_value;
        end
    end

    // Slot memories: one write and one registered read per cycle, both at r_idx.
    always_ff @(posedge i_clk) begin
        if (i_cmd.write_key) begin
            r_key_mem[r_idx] <= r_nkey;
        end
        if (i_cmd.write_value) begin
            r_val_mem[r_idx] <= r_value;
        end
        r_rd_key <= r_key_mem[r_idx];
        r_rd_val <= r_val_mem[r_idx];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used <= '0;
        end else if (i_cmd.set_used) begin
            r_used[r_idx] <= 1'b1;
        end
    end

    assign o_sts.is_get     = r_is_get;
    assign o_sts.hkey_zero  = (r_hkey == '0);
    assign o_sts.slot_used  = r_used[r_idx];
    assign o_sts.key_match  = (r_rd_key == r_nkey);
    assign o_sts.probe_last = (r_probe_cnt == SLOT_W'(TABLE_SLOTS - 1));

    assign o_status     = r_out_status;
    assign o_read_value = r_out_value;

    a_insert_free_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.write_key |-> !r_used[r_idx])
        else $error("insert into an occupied slot");

    a_update_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.write_value && !i_cmd.write_key) |-> (r_used[r_idx] && r_rd_key == r_nkey))
        else $error("update of a slot holding another key");

    a_hash_finished: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.probe_start |-> (r_hkey == '0))
        else $error("probing started before the hash consumed every key byte");

endmodule

[hdl/fnv1a_linear_probe_hash_table_core.sv]
// Key-value table, FNV-1a hashed, linear probing. An accepted request first hashes
// its nonzero key bytes, one byte a cycle, then probes slots, and then loads the
// result word; each probe is a slot memory read and a compare, and the compare is
// skipped when the slot probed is empty. One request is in flight at a time; the
// next is taken in the cycle after the result word is loaded, which waits while an
// earlier word is stalled. Synchronous reset clears all used bits.
`timescale 1ns / 1ps

module fnv1a_linear_probe_hash_table_core (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_valid,
    output logic                                 o_stall,
    input  logic                                 i_req_type,
    input  logic        [fnvlp_pkg::KEY_W-1:0]   i_key,
    input  logic signed [fnvlp_pkg::VALUE_W-1:0] i_value,
    output logic                                 o_valid,
    input  logic                                 i_stall,
    output logic        [2:0]                    o_status,
    output logic signed [fnvlp_pkg::VALUE_W-1:0] o_read_value
);
    import fnvlp_pkg::*;

    t_dp_cmd cmd;
    t_dp_sts sts;

    fnvlp_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    fnvlp_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_sts        (sts),
        .i_req_type   (i_req_type),
        .i_key        (i_key),
        .i_value      (i_value),
        .o_status     (o_status),
        .o_read_value (o_read_value)
    );

endmodule

[tb/sv/tb_top.sv]
// Self-checking testbench for fnv1a_linear_probe_hash_table_core: puts and gets driven
// with random gaps, results checked against an in-bench table model with FNV-1a hashing.
// Depends on fnvlp_pkg for sizes, request codes and status codes.
`timescale 1ns / 1ps

module tb_top;
    import fnvlp_pkg::*;

    localparam int CYCLE_LIMIT  = 1_500_000;
    localparam int POOL_REQS    = 950;
    localparam int FULL_REQS    = 400;
    localparam int TAIL_CYCLES  = 200;

    typedef struct {
        t_status            status;
        logic [VALUE_W-1:0] read_value;
    } t_table_reply;

    logic                      i_clk = 1'b0;
    logic                      i_rst_n;
    logic                      i_valid;
    logic                      o_stall;
    logic                      i_req_type;
    logic        [KEY_W-1:0]   i_key;
    logic signed [VALUE_W-1:0] i_value;
    logic                      o_valid;
    logic                      i_stall = 1'b0;
    logic        [2:0]         o_status;
    logic signed [VALUE_W-1:0] o_read_value;

    // Table model: contents, occupancy and the keys stored so far.
    logic [KEY_W-1:0]   tbl_key  [TABLE_SLOTS];
    logic [VALUE_W-1:0] tbl_val  [TABLE_SLOTS];
    logic               tbl_used [TABLE_SLOTS];
    int                 tbl_count;
    logic [KEY_W-1:0]   known_keys[$];
    logic [KEY_W-1:0]   key_pool[$];

    t_table_reply reply_q[$];
    t_table_reply got_reply;
    int           status_tally[5];
    int           req_count;
    int           mismatch_count;
    int           cycle_count;
    bit           idle_on;
    int           stall_left;

    fnv1a_linear_probe_hash_table_core dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_req_type   (i_req_type),
        .i_key        (i_key),
        .i_value      (i_value),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_status     (o_status),
        .o_read_value (o_read_value)
    );

    always #10 i_clk = ~i_clk;

    // Number of leading nonzero bytes, which is the length of the key.
    function automatic int key_len(input logic [KEY_W-1:0] raw);
        int n;
        n = 0;
        while (n < KEY_BYTES && raw[8*n +: 8] != 8'h00) n++;
        return n;
    endfunction

    function automatic logic [KEY_W-1:0] trim_key(input logic [KEY_W-1:0] raw);
        logic [KEY_W-1:0] k;
        int               len;
        k   = '0;
        len = key_len(raw);
        for (int i = 0; i < len; i++) k[8*i +: 8] = raw[8*i +: 8];
        return k;
    endfunction

    function automatic logic [HASH_W-1:0] fnv1a(input logic [KEY_W-1:0] nkey);
        logic [HASH_W-1:0] h;
        h = FNV_BASIS;
        for (int i = 0; i < KEY_W / 8; i++) begin
            if (nkey[8*i +: 8] == 8'h00) break;
            h = (h ^ {24'h0, nkey[8*i +: 8]}) * FNV_PRIME;
        end
        return h;
    endfunction

    // Applies one request to the table model and returns the word it should produce.
    function automatic void table_access(input logic req, input logic [KEY_W-1:0] raw,
                                         input logic [VALUE_W-1:0] val,
                                         output t_table_reply reply);
        logic [KEY_W-1:0] nkey;
        int               slot;
        nkey = trim_key(raw);
        slot = int'(fnv1a(nkey) % TABLE_SLOTS);
        reply.status     = (req == REQ_GET) ? ST_NOT_FOUND : ST_FULL;
        reply.read_value = '0;
        for (int n = 0; n < TABLE_SLOTS; n++) begin
            if (!tbl_used[slot]) begin
                if (req == REQ_PUT) begin
                    tbl_key[slot]  = nkey;
                    tbl_val[slot]  = val;
                    tbl_used[slot] = 1'b1;
                    tbl_count++;
                    known_keys.push_back(nkey);
                    reply.status = ST_INSERTED;
                end
                break;
            end
            if (tbl_key[slot] == nkey) begin
                if (req == REQ_GET) begin
                    reply.read_value = tbl_val[slot];
                    reply.status     = ST_FOUND;
                end else begin
                    tbl_val[slot] = val;
                    reply.status  = ST_UPDATED;
                end
                break;
            end
            slot = (slot + 1) % TABLE_SLOTS;
        end
        status_tally[int'(reply.status)]++;
    endfunction

    function automatic int pick_gap();
        int r;
        if (!idle_on) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // Random key of 0..8 bytes, sometimes with junk after the terminator.
    function automatic logic [KEY_W-1:0] random_key();
        logic [KEY_W-1:0] k;
        int               r;
        int               len;
        k   = '0;
        r   = $urandom_range(0, 99);
        len = (r < 3) ? 0 : (r < 70) ? $urandom_range(1, 4) : $urandom_range(5, 8);
        for (int i = 0; i < len; i++) k[8*i +: 8] = 8'($urandom_range(1, 255));
        if (len < 7 && $urandom_range(0, 1) == 1) begin
            for (int i = len + 1; i < 8; i++) k[8*i +: 8] = 8'($urandom_range(0, 255));
        end
        return k;
    endfunction

    // Same key as seen by the table, sometimes with random bytes after the terminator.
    function automatic logic [KEY_W-1:0] add_tail(input logic [KEY_W-1:0] nkey);
        logic [KEY_W-1:0] k;
        int               len;
        k   = nkey;
        len = key_len(nkey);
        if (len < 7 && $urandom_range(0, 1) == 1) begin
            for (int i = len + 1; i < 8; i++) k[8*i +: 8] = 8'($urandom_range(0, 255));
        end
        return k;
    endfunction

    function automatic logic [VALUE_W-1:0] random_value();
        case ($urandom_range(0, 39))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 32'h0000_0000;
            3: return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    task automatic send_req(input logic req, input logic [KEY_W-1:0] k,
                            input logic [VALUE_W-1:0] v);
        int           gap;
        t_table_reply reply;
        gap = pick_gap();
        @(negedge i_clk);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid    <= 1'b1;
        i_req_type <= req;
        i_key      <= k;
        i_value    <= v;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        table_access(req, k, v, reply);
        reply_q.push_back(reply);
        req_count++;
    endtask

    task automatic wait_drain();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (reply_q.size() != 0) @(posedge i_clk);
    endtask

    task automatic note_mismatch(input string what, input logic [31:0] want,
                                 input logic [31:0] got);
        mismatch_count++;
        if (mismatch_count <= 10) begin
            $display("Mismatch at cycle %0d: %s expected %h, got %h",
                     cycle_count, what, want, got);
        end
    endtask

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles with %0d words outstanding",
                     cycle_count, reply_q.size());
            $display("CHECK FAILED");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            if (reply_q.size() == 0) begin
                note_mismatch("word with no request pending, status", '0, 32'(o_status));
            end else begin
                got_reply = reply_q.pop_front();
                if (o_status !== got_reply.status) begin
                    note_mismatch("status", 32'(got_reply.status), 32'(o_status));
                end
                if (o_read_value !== got_reply.read_value) begin
                    note_mismatch("read_value", got_reply.read_value, o_read_value);
                end
            end
        end
    end

    // Result side back-pressure, in bursts of random length.
    always @(negedge i_clk) begin
        if (stall_left > 0) begin
            stall_left--;
            i_stall <= 1'b1;
        end else if (i_rst_n && idle_on && $urandom_range(0, 99) < 25) begin
            stall_left = pick_gap();
            i_stall <= 1'b1;
        end else begin
            i_stall <= 1'b0;
        end
    end

    task automatic test_empty_table();
        send_req(REQ_GET, 64'h0000_0000_0063_6261, 32'h1234_5678);
        send_req(REQ_GET, 64'h0, 32'h0);
    endtask

    task automatic test_key_edges();
        // The empty key is a key of its own; junk after the terminator must not matter.
        send_req(REQ_PUT, 64'h0, 32'h7FFF_FFFF);
        send_req(REQ_PUT, 64'hFFFF_FFFF_FFFF_FF00, 32'h8000_0000);
        send_req(REQ_GET, 64'h1234_5678_9ABC_DE00, 32'h0);
        send_req(REQ_PUT, 64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF);
        send_req(REQ_GET, 64'hFFFF_FFFF_FFFF_FFFF, 32'h0);
        send_req(REQ_PUT, 64'h0000_0000_0000_0041, 32'h0000_0001);
        send_req(REQ_GET, 64'hDEAD_BEEF_CAFE_0041, 32'hFFFF_FFFF);
        send_req(REQ_PUT, 64'h0807_0605_0403_0201, 32'h0);
        send_req(REQ_GET, 64'h0107_0605_0403_0201, 32'h0);
        send_req(REQ_PUT, 64'h0807_0605_0403_0201, 32'h5A5A_5A5A);
        send_req(REQ_GET, 64'h0807_0605_0403_0201, 32'h0);
    endtask

    task automatic test_probe_wrap();
        logic [KEY_W-1:0] wrap_keys[$];
        logic [KEY_W-1:0] cand;
        // Keys that all hash to the last slot, so their probe chain wraps to slot 0.
        while (wrap_keys.size() < 4) begin
            cand = '0;
            for (int i = 0; i < 3; i++) cand[8*i +: 8] = 8'($urandom_range(1, 255));
            if (fnv1a(cand) % TABLE_SLOTS == TABLE_SLOTS - 1) wrap_keys.push_back(cand);
        end
        for (int i = 0; i < 3; i++) send_req(REQ_PUT, wrap_keys[i], random_value());
        for (int i = 0; i < 4; i++) send_req(REQ_GET, add_tail(wrap_keys[i]), random_value());
    endtask

    task automatic test_random_pool();
        logic [KEY_W-1:0] k;
        for (int i = 0; i < 30; i++) key_pool.push_back(trim_key(random_key()));
        for (int i = 0; i < POOL_REQS; i++) begin
            idle_on = (i < 300 || i >= 450);
            if (i == 600) wait_drain();
            if ($urandom_range(0, 99) < 45) begin
                k = ($urandom_range(0, 99) < 98) ?
                    add_tail(key_pool[$urandom_range(0, key_pool.size() - 1)]) : random_key();
                send_req(REQ_PUT, k, random_value());
            end else begin
                k = ($urandom_range(0, 99) < 90) ?
                    add_tail(key_pool[$urandom_range(0, key_pool.size() - 1)]) : random_key();
                send_req(REQ_GET, k, random_value());
            end
        end
    endtask

    task automatic test_fill_table();
        wait_drain();
        while (tbl_count < TABLE_SLOTS) send_req(REQ_PUT, random_key(), random_value());
    endtask

    task automatic test_full_table();
        logic [KEY_W-1:0] k;
        // Known keys still update on a full table; new keys are rejected or not found.
        for (int i = 0; i < FULL_REQS; i++) begin
            if ($urandom_range(0, 1) == 0) begin
                k = ($urandom_range(0, 1) == 0) ?
                    add_tail(known_keys[$urandom_range(0, known_keys.size() - 1)]) : random_key();
                send_req(REQ_PUT, k, random_value());
            end else begin
                k = ($urandom_range(0, 99) < 60) ?
                    add_tail(known_keys[$urandom_range(0, known_keys.size() - 1)]) : random_key();
                send_req(REQ_GET, k, random_value());
            end
        end
    endtask

    initial begin
        i_rst_n    = 1'b0;
        i_valid    = 1'b0;
        i_req_type = REQ_PUT;
        i_key      = '0;
        i_value    = '0;
        idle_on    = 1'b1;
        tbl_count  = 0;
        foreach (tbl_used[s]) tbl_used[s] = 1'b0;
        foreach (status_tally[s]) status_tally[s] = 0;

        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_empty_table();
        test_key_edges();
        test_probe_wrap();
        test_random_pool();
        test_fill_table();
        test_full_table();

        @(negedge i_clk);
        i_valid <= 1'b0;
        while (reply_q.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("Ran %0d requests: %0d inserted, %0d updated, %0d found, %0d not found, %0d full",
                 req_count, status_tally[ST_INSERTED], status_tally[ST_UPDATED],
                 status_tally[ST_FOUND], status_tally[ST_NOT_FOUND], status_tally[ST_FULL]);
        $display("Table ended with %0d of %0d slots used; %0d mismatches in %0d cycles",
                 tbl_count, TABLE_SLOTS, mismatch_count, cycle_count);
        if (mismatch_count == 0 && reply_q.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
